// ===== src/lsd_radix_sort_records_macros.svh =====
// ----------------------------------------------------------------------------
// lsd_radix_sort_records_macros.svh
// Assertion macros shared by the radix sort block. Each macro expects aclk
// and aresetn to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef LSD_RADIX_SORT_RECORDS_MACROS_SVH
`define LSD_RADIX_SORT_RECORDS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LSDRS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lsdrs same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define LSDRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lsdrs next-cycle check failed");

`endif

// ===== src/lsdrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lsdrs_pkg
// Types, sizes and arithmetic helpers of the base-10 LSD radix sort block.
// ----------------------------------------------------------------------------
package lsdrs_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int CNT_W       = 7;
    localparam int KEY_W       = 16;
    localparam int TAG_W       = 6;
    localparam int RADIX       = 10;
    localparam int DIGIT_W     = 4;

    // Reciprocal of ten, exact for every 16-bit dividend
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef struct packed {
        logic [KEY_W-1:0] sort_key;
        logic [TAG_W-1:0] record_tag;
        logic             is_last;
    } in_t;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0] sorted_tag;
        logic             last_out;
        logic             overflowed;
    } out_t;

    // Stored record: remaining quotient of the key, the key and the tag
    typedef struct packed {
        logic [KEY_W-1:0] quot;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } rec_t;

    // Divide a 16-bit value by ten through the reciprocal
    function automatic logic [KEY_W-1:0] div10(input logic [KEY_W-1:0] q);
        logic [31:0] p;
        p = 32'(q) * 32'(DIV10_MUL);
        return KEY_W'(p >> DIV10_SHIFT);
    endfunction

    // Lowest decimal digit of q, given q divided by ten
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [KEY_W-1:0] q,
                                                    input logic [KEY_W-1:0] quot);
        logic [KEY_W-1:0] r;
        r = q - ((quot << 3) + (quot << 1));
        return r[DIGIT_W-1:0];
    endfunction

endpackage

// ===== src/lsd_radix_sort_records.sv =====
// ----------------------------------------------------------------------------
// lsd_radix_sort_records
// Loading takes one record per cycle. After the last record, each pass over n
// records runs a check, a count sweep, a ten-step prefix and a scatter sweep,
// one pass per decimal digit of the largest key (0 to 5), then a final check.
// Each result passes memory read, output load and handshake before the next
// is read. Reset clears control state only; record memories keep contents.
// ----------------------------------------------------------------------------
`include "lsd_radix_sort_records_macros.svh"

module lsd_radix_sort_records
    import lsdrs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam logic [2:0] ST_LOAD     = 3'd0;
    localparam logic [2:0] ST_CHECK    = 3'd1;
    localparam logic [2:0] ST_COUNT    = 3'd2;
    localparam logic [2:0] ST_PREFIX   = 3'd3;
    localparam logic [2:0] ST_SCATTER  = 3'd4;
    localparam logic [2:0] ST_OUT_RD   = 3'd5;
    localparam logic [2:0] ST_OUT_LD   = 3'd6;
    localparam logic [2:0] ST_OUT_WAIT = 3'd7;

    // Control state
    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   entry_count_reg, entry_count_next;
    logic               dropped_reg, dropped_next;
    logic               src_sel_reg, src_sel_next;
    logic [KEY_W-1:0]   largest_reg, largest_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               pipe_valid_reg, pipe_valid_next;
    logic [CNT_W-1:0]   counts_reg [RADIX], counts_next [RADIX];
    logic [DIGIT_W-1:0] pfx_idx_reg, pfx_idx_next;
    logic [CNT_W-1:0]   pfx_sum_reg, pfx_sum_next;
    logic               m_valid_reg, m_valid_next;

    // Payload state
    rec_t               pipe_rec_reg, pipe_rec_next;
    logic [KEY_W-1:0]   pipe_quot_reg, pipe_quot_next;
    out_t               m_data_reg, m_data_next;

    // Memory ports
    rec_t               mem0 [STORE_DEPTH];
    rec_t               mem1 [STORE_DEPTH];
    rec_t               rd0_reg, rd1_reg, rd_word;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en, wr_sel;
    logic [ADDR_W-1:0]  wr_addr;
    rec_t               wr_data;

    logic               issue;
    logic               pipe_busy;
    logic [DIGIT_W-1:0] digit;

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Record memories: one write port, one registered read port each
    always_ff @(posedge aclk) begin
        if (wr_en && !wr_sel) begin
            mem0[wr_addr] <= wr_data;
        end
        rd0_reg <= mem0[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_sel) begin
            mem1[wr_addr] <= wr_data;
        end
        rd1_reg <= mem1[rd_addr];
    end

    assign rd_addr   = idx_reg[ADDR_W-1:0];
    assign rd_word   = src_sel_reg ? rd1_reg : rd0_reg;
    assign issue     = ((state_reg == ST_COUNT) || (state_reg == ST_SCATTER))
                       && (idx_reg < entry_count_reg);
    assign pipe_busy = rd_valid_reg || pipe_valid_reg;
    assign digit     = digit_of(pipe_rec_reg.quot, pipe_quot_reg);

    // Sequence load, sort passes and emission
    always_comb begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        dropped_next     = dropped_reg;
        src_sel_next     = src_sel_reg;
        largest_next     = largest_reg;
        idx_next         = idx_reg;
        pfx_idx_next     = pfx_idx_reg;
        pfx_sum_next     = pfx_sum_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        for (int i = 0; i < RADIX; i++) begin
            counts_next[i] = counts_reg[i];
        end

        // Read pipeline: memory data, then quotient stage
        rd_valid_next   = issue;
        pipe_valid_next = rd_valid_reg;
        pipe_rec_next   = rd_word;
        pipe_quot_next  = div10(rd_word.quot);

        wr_en   = 1'b0;
        wr_sel  = 1'b0;
        wr_addr = entry_count_reg[ADDR_W-1:0];
        wr_data = '{quot: s_data.sort_key, key: s_data.sort_key, tag: s_data.record_tag};

        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (entry_count_reg < CNT_W'(MAX_ENTRIES)) begin
                        wr_en            = 1'b1;
                        entry_count_next = entry_count_reg + CNT_W'(1);
                        if (s_data.sort_key > largest_reg) begin
                            largest_next = s_data.sort_key;
                        end
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_data.is_last) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                for (int i = 0; i < RADIX; i++) begin
                    counts_next[i] = '0;
                end
                idx_next   = '0;
                state_next = (largest_reg == '0) ? ST_OUT_RD : ST_COUNT;
            end
            ST_COUNT: begin
                if (issue) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (pipe_valid_reg) begin
                    counts_next[digit] = counts_reg[digit] + CNT_W'(1);
                end
                if (!issue && !pipe_busy) begin
                    idx_next     = '0;
                    pfx_idx_next = '0;
                    pfx_sum_next = '0;
                    state_next   = ST_PREFIX;
                end
            end
            ST_PREFIX: begin
                // Turn counts into start offsets, one digit a cycle
                counts_next[pfx_idx_reg] = pfx_sum_reg;
                pfx_sum_next = pfx_sum_reg + counts_reg[pfx_idx_reg];
                pfx_idx_next = pfx_idx_reg + DIGIT_W'(1);
                if (pfx_idx_reg == DIGIT_W'(RADIX - 1)) begin
                    state_next = ST_SCATTER;
                end
            end
            ST_SCATTER: begin
                if (issue) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (pipe_valid_reg) begin
                    wr_en   = 1'b1;
                    wr_sel  = !src_sel_reg;
                    wr_addr = counts_reg[digit][ADDR_W-1:0];
                    wr_data = '{quot: pipe_quot_reg, key: pipe_rec_reg.key,
                                tag: pipe_rec_reg.tag};
                    counts_next[digit] = counts_reg[digit] + CNT_W'(1);
                end
                if (!issue && !pipe_busy) begin
                    src_sel_next = !src_sel_reg;
                    largest_next = div10(largest_reg);
                    idx_next     = '0;
                    state_next   = ST_CHECK;
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                m_data_next.sorted_key = rd_word.key;
                m_data_next.sorted_tag = rd_word.tag;
                m_data_next.last_out   = ((idx_reg + CNT_W'(1)) == entry_count_reg);
                m_data_next.overflowed = dropped_reg;
                m_valid_next           = 1'b1;
                state_next             = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_data_reg.last_out) begin
                        entry_count_next = '0;
                        dropped_next     = 1'b0;
                        src_sel_next     = 1'b0;
                        largest_next     = '0;
                        idx_next         = '0;
                        state_next       = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold control state, clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            entry_count_reg <= '0;
            dropped_reg     <= 1'b0;
            src_sel_reg     <= 1'b0;
            largest_reg     <= '0;
            idx_reg         <= '0;
            rd_valid_reg    <= 1'b0;
            pipe_valid_reg  <= 1'b0;
            pfx_idx_reg     <= '0;
            pfx_sum_reg     <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < RADIX; i++) begin
                counts_reg[i] <= '0;
            end
        end else begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            dropped_reg     <= dropped_next;
            src_sel_reg     <= src_sel_next;
            largest_reg     <= largest_next;
            idx_reg         <= idx_next;
            rd_valid_reg    <= rd_valid_next;
            pipe_valid_reg  <= pipe_valid_next;
            pfx_idx_reg     <= pfx_idx_next;
            pfx_sum_reg     <= pfx_sum_next;
            m_valid_reg     <= m_valid_next;
            for (int i = 0; i < RADIX; i++) begin
                counts_reg[i] <= counts_next[i];
            end
        end
    end

    // Advance payload registers
    always_ff @(posedge aclk) begin
        pipe_rec_reg  <= pipe_rec_next;
        pipe_quot_reg <= pipe_quot_next;
        m_data_reg    <= m_data_next;
    end

    // Checks
    `LSDRS_ASSERT_SAME(a_load_excludes_output, s_ready, !m_valid)
    `LSDRS_ASSERT_SAME(a_count_in_range, 1'b1, entry_count_reg <= CNT_W'(MAX_ENTRIES))
    `LSDRS_ASSERT_SAME(a_digit_decimal, pipe_valid_reg, digit < DIGIT_W'(RADIX))
    `LSDRS_ASSERT_NEXT(a_reload_after_run, m_valid && m_ready && m_data.last_out, s_ready)

endmodule
